[rtl/core/stack_with_reverse_assert.svh]
// Assertion macros shared by the stack checker.
// Depends on nothing; the includer supplies clock, reset and expressions.
`ifndef STACK_WITH_REVERSE_ASSERT_SVH
`define STACK_WITH_REVERSE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SWR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SWR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/swr_pkg.sv]
// Shared types and constants for the LIFO stack with in-place reverse.
// Used by the stack top level and its checker; depends on nothing.
package swr_pkg;

   localparam int DEPTH_DEFAULT = 256;
   localparam int WORD_W        = 32;
   localparam int FILL_W        = 9;
   localparam int MODE_W        = 2;
   localparam int STAT_W        = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH = 2'd0,
      MODE_POP  = 2'd1,
      MODE_REV  = 2'd2
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_RD,
      ST_REV_RD_LO,
      ST_REV_RD_HI,
      ST_REV_WR_LO,
      ST_REV_WR_HI,
      ST_RESP
   } state_type;

endpackage

[rtl/core/swr_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Self-contained; used for the stack storage.
module swr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data appears the cycle after the address.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/stack_with_reverse.sv]
// Channel   | Signals                                  | Direction
// ----------+------------------------------------------+----------
// request   | req_valid, req_stall, req_mode, req_value | in
// response  | rsp_valid, rsp_stall, rsp_data_out,       | out
//           | rsp_fill_count, rsp_is_empty, rsp_is_full, |
//           | rsp_status                                 |
//
// Push, refused operations and the unused mode go from idle straight to the response.
// Pop passes through a read step when an element remains, since the new top is read back.
// Reverse of n >= 2 elements swaps pairs from the ends inward: each swapped pair
// needs two reads and two writes through the single RAM read and write port.
// Reset clears the fill count and state only; the RAM is not swept.
// A stalled response holds, and no request beat is taken until it is delivered.
module stack_with_reverse
   import swr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [WORD_W-1:0] req_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [WORD_W-1:0] rsp_data_out,
   output logic [FILL_W-1:0] rsp_fill_count,
   output logic              rsp_is_empty,
   output logic              rsp_is_full,
   output logic [STAT_W-1:0] rsp_status
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int EXT_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] top_ff, top_in;
   logic [WORD_W-1:0] data_ff, data_in;
   status_type        status_ff, status_in;
   logic [AW-1:0]     lo_ff, lo_in;
   logic [AW-1:0]     hi_ff, hi_in;
   logic [WORD_W-1:0] lo_word_ff, lo_word_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [WORD_W-1:0] rd_data;

   logic              is_full;
   logic              is_empty;
   logic              has_two;
   logic              more_pairs;
   logic [EXT_W-1:0]  count_ext;
   mode_type          req_mode_t;

   // Stack storage.
   swr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Fill status of the stack as it stands.
   assign is_full    = (count_ff == CNT_W'(DEPTH));
   assign is_empty   = (count_ff == '0);
   assign has_two    = (count_ff >= CNT_W'(2));
   assign more_pairs = (({1'b0, hi_ff} - {1'b0, lo_ff}) > (AW+1)'(2));
   assign req_mode_t = mode_type'(req_mode);

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RESP;
               if ((req_mode_t == MODE_POP) && has_two) begin
                  state_in = ST_POP_RD;
               end
               if ((req_mode_t == MODE_REV) && has_two) begin
                  state_in = ST_REV_RD_HI;
               end
            end
         end
         ST_POP_RD:    state_in = ST_RESP;
         ST_REV_RD_LO: state_in = ST_REV_RD_HI;
         ST_REV_RD_HI: state_in = ST_REV_WR_LO;
         ST_REV_WR_LO: state_in = ST_REV_WR_HI;
         ST_REV_WR_HI: state_in = more_pairs ? ST_REV_RD_LO : ST_RESP;
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // Datapath and RAM controls for each sequencer step.
   always_comb begin
      count_in   = count_ff;
      top_in     = top_ff;
      data_in    = data_ff;
      status_in  = status_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      lo_word_in = lo_word_ff;
      wr_en      = 1'b0;
      wr_addr    = lo_ff;
      wr_data    = rd_data;
      rd_en      = 1'b0;
      rd_addr    = lo_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               status_in = STAT_OK;
               data_in   = is_empty ? '0 : top_ff;
               unique case (req_mode_t)
                  MODE_PUSH: begin
                     if (is_full) begin
                        status_in = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = AW'(count_ff);
                        wr_data  = req_value;
                        count_in = count_ff + 1'b1;
                        top_in   = req_value;
                        data_in  = req_value;
                     end
                  end
                  MODE_POP: begin
                     if (is_empty) begin
                        status_in = STAT_EMPTY;
                        data_in   = '0;
                     end else begin
                        data_in  = top_ff;
                        count_in = count_ff - 1'b1;
                        // The element below the popped one becomes the top.
                        if (has_two) begin
                           rd_en   = 1'b1;
                           rd_addr = AW'(count_ff - CNT_W'(2));
                        end
                     end
                  end
                  MODE_REV: begin
                     if (has_two) begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        lo_in   = '0;
                        hi_in   = AW'(count_ff - 1'b1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POP_RD: begin
            top_in = rd_data;
         end
         ST_REV_RD_LO: begin
            rd_en   = 1'b1;
            rd_addr = lo_ff;
         end
         ST_REV_RD_HI: begin
            rd_en      = 1'b1;
            rd_addr    = hi_ff;
            lo_word_in = rd_data;
            // The bottom element becomes the new top.
            if (lo_ff == '0) begin
               top_in  = rd_data;
               data_in = rd_data;
            end
         end
         ST_REV_WR_LO: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            wr_data = rd_data;
         end
         ST_REV_WR_HI: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = lo_word_ff;
            lo_in   = lo_ff + 1'b1;
            hi_in   = hi_ff - 1'b1;
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      top_ff     <= top_in;
      data_ff    <= data_in;
      status_ff  <= status_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      lo_word_ff <= lo_word_in;
   end

   // Response beat.
   assign count_ext      = EXT_W'(count_ff);
   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_RESP);
   assign rsp_data_out   = data_ff;
   assign rsp_fill_count = count_ext[FILL_W-1:0];
   assign rsp_is_empty   = is_empty;
   assign rsp_is_full    = is_full;
   assign rsp_status     = status_ff;

endmodule

[rtl/core/swr_checker.sv]
// Port-level checker for the LIFO stack, bound to the top level.
// Depends on swr_pkg and the assertion macros in stack_with_reverse_assert.svh.
`include "stack_with_reverse_assert.svh"

module swr_checker
   import swr_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [WORD_W-1:0] rsp_data_out,
   input logic              rsp_is_empty,
   input logic              rsp_is_full,
   input logic [STAT_W-1:0] rsp_status
);

   logic rsp_wait;
   logic req_take;
   logic refused_full;
   logic refused_empty;
   logic full_ok;
   logic empty_ok;

   assign rsp_wait      = rsp_valid && rsp_stall;
   assign req_take      = req_valid && !req_stall;
   assign refused_full  = rsp_valid && (rsp_status == STAT_FULL);
   assign refused_empty = rsp_valid && (rsp_status == STAT_EMPTY);
   assign full_ok       = rsp_is_full && !rsp_is_empty;
   assign empty_ok      = rsp_is_empty && (rsp_data_out == '0);

   // No request beat is taken while a result is still pending.
   `SWR_ASSERT_NOW(a_one_at_a_time, clock, reset, req_take, !rsp_valid, "beat taken in response")
   // A refused push only happens on a full stack.
   `SWR_ASSERT_NOW(a_full_status, clock, reset, refused_full, full_ok, "bad full status")
   // A refused pop only happens on an empty stack and returns zero.
   `SWR_ASSERT_NOW(a_empty_status, clock, reset, refused_empty, empty_ok, "bad empty status")
   // A stalled response beat stays offered.
   `SWR_ASSERT_NEXT(a_rsp_stay, clock, reset, rsp_wait, rsp_valid, "stalled beat dropped")
   // A stalled response beat holds its word.
   `SWR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, $stable(rsp_data_out), "word changed")

endmodule

bind stack_with_reverse swr_checker u_swr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_data_out (rsp_data_out),
   .rsp_is_empty (rsp_is_empty),
   .rsp_is_full  (rsp_is_full),
   .rsp_status   (rsp_status)
);
